>>> hdl/tpp_pkg.sv
// tpp_pkg: shared types and constants for the telecentric point projection
// holds the register map and the configuration struct; no dependencies
package tpp_pkg;

    localparam int NumRegs  = 8;
    localparam int AddrBits = 6;
    localparam int DataBits = 64;
    localparam int NStages  = 14;

    typedef enum logic [2:0] {
        REG_MAG    = 3'd0,
        REG_PP     = 3'd1,
        REG_K1     = 3'd2,
        REG_K2     = 3'd3,
        REG_K3     = 3'd4,
        REG_TANG   = 3'd5,
        REG_PRISMX = 3'd6,
        REG_PRISMY = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic        [31:0] mag;
        logic signed [31:0] u0;
        logic signed [31:0] v0;
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] k3;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
        logic signed [31:0] s1;
        logic signed [31:0] s2;
        logic signed [31:0] s3;
        logic signed [31:0] s4;
    } cfg_t;

endpackage

>>> hdl/tpp_cfg.sv
// tpp_cfg: apb register file for the projection coefficients
// depends on tpp_pkg for the register map and cfg_t
module tpp_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tpp_pkg::AddrBits-1:0]   paddr,
    input  logic [tpp_pkg::DataBits-1:0]   pwdata,
    output logic [tpp_pkg::DataBits-1:0]   prdata,
    output logic                           pready,
    output tpp_pkg::cfg_t                  cfg
);

    tpp_pkg::cfg_t    cfg_reg;
    tpp_pkg::reg_idx_t idx;

    assign idx    = tpp_pkg::reg_idx_t'(paddr[5:3]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                tpp_pkg::REG_MAG:    cfg_reg.mag <= pwdata[31:0];
                tpp_pkg::REG_PP:
                begin
                    cfg_reg.u0 <= pwdata[63:32];
                    cfg_reg.v0 <= pwdata[31:0];
                end
                tpp_pkg::REG_K1:     cfg_reg.k1 <= pwdata[31:0];
                tpp_pkg::REG_K2:     cfg_reg.k2 <= pwdata[31:0];
                tpp_pkg::REG_K3:     cfg_reg.k3 <= pwdata[31:0];
                tpp_pkg::REG_TANG:
                begin
                    cfg_reg.p1 <= pwdata[63:32];
                    cfg_reg.p2 <= pwdata[31:0];
                end
                tpp_pkg::REG_PRISMX:
                begin
                    cfg_reg.s1 <= pwdata[63:32];
                    cfg_reg.s2 <= pwdata[31:0];
                end
                tpp_pkg::REG_PRISMY:
                begin
                    cfg_reg.s3 <= pwdata[63:32];
                    cfg_reg.s4 <= pwdata[31:0];
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            tpp_pkg::REG_MAG:    prdata = {32'd0, cfg_reg.mag};
            tpp_pkg::REG_PP:     prdata = {cfg_reg.u0, cfg_reg.v0};
            tpp_pkg::REG_K1:     prdata = {{32{cfg_reg.k1[31]}}, cfg_reg.k1};
            tpp_pkg::REG_K2:     prdata = {{32{cfg_reg.k2[31]}}, cfg_reg.k2};
            tpp_pkg::REG_K3:     prdata = {{32{cfg_reg.k3[31]}}, cfg_reg.k3};
            tpp_pkg::REG_TANG:   prdata = {cfg_reg.p1, cfg_reg.p2};
            tpp_pkg::REG_PRISMX: prdata = {cfg_reg.s1, cfg_reg.s2};
            tpp_pkg::REG_PRISMY: prdata = {cfg_reg.s3, cfg_reg.s4};
            default:             prdata = '0;
        endcase
    end

endmodule

>>> hdl/tpp_pipe.sv
// tpp_pipe: fourteen stage projection datapath with global stall
// depends on tpp_pkg for cfg_t
module tpp_pipe (
    input  logic               clk,
    input  logic               rst_n,
    input  tpp_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] obj_x,
    input  logic signed [31:0] obj_y,
    input  logic signed [31:0] rot_xx,
    input  logic signed [31:0] rot_xy,
    input  logic signed [31:0] rot_yx,
    input  logic signed [31:0] rot_yy,
    input  logic signed [31:0] shift_x,
    input  logic signed [31:0] shift_y,
    input  logic               last_point,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] img_u,
    output logic signed [31:0] img_v,
    output logic               end_of_view
);

    typedef struct packed {
        logic               last;
        logic signed [31:0] tx, ty;
        logic signed [63:0] pa, pb, pc, pd;
        logic signed [31:0] xn, yn;
        logic signed [63:0] mxx, myy, mxy;
        logic signed [31:0] r2, xx, yy, xy;
        logic signed [63:0] m_r2r2, m_k1, m_s1, m_s3, m_p1xy, m_p2xy;
        logic signed [31:0] sx, sy;
        logic signed [31:0] r4, c_k1, c_s1, c_s3, c_p1xy, c_p2xy;
        logic signed [63:0] m_p2sx, m_p1sy;
        logic signed [63:0] m_r6, m_k2, m_s2, m_s4;
        logic signed [31:0] c_p2sx, c_p1sy;
        logic signed [31:0] r6, c_k2, c_s2, c_s4;
        logic signed [63:0] m_k3;
        logic signed [31:0] radial;
        logic signed [63:0] m_xr, m_yr;
        logic signed [31:0] xd, yd;
        logic signed [64:0] m_u, m_v;
        logic signed [31:0] u, v;
    } stage_t;

    stage_t                     st_reg  [tpp_pkg::NStages];
    stage_t                     st_next [tpp_pkg::NStages];
    logic [tpp_pkg::NStages-1:0] vld_reg;
    logic                       adv;
    logic [64:0]                sq;
    logic [48:0]                r2u;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -66'sh0_8000_0000)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [65:0] rnd(input logic signed [65:0] v, input int s);
        logic signed [65:0] bias;
        bias = 66'sd1 <<< (s - 1);
        return (v + bias) >>> s;
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [63:0] p);
        return sat32(rnd(66'(p), 16));
    endfunction

    function automatic logic signed [31:0] cmul(input logic signed [63:0] p);
        logic signed [65:0] q;
        q = rnd(66'(p), 40);
        return q[31:0];
    endfunction

    assign adv      = !vld_reg[tpp_pkg::NStages-1] || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        st_next[0] = st_reg[0];
        for (int i = 1; i < tpp_pkg::NStages; i++)
            st_next[i] = st_reg[i-1];
        sq  = 65'(unsigned'(st_reg[2].mxx)) + 65'(unsigned'(st_reg[2].myy));
        r2u = 49'((sq + 65'd32768) >> 16);

        // rotation products
        st_next[0].last = last_point;
        st_next[0].tx   = shift_x;
        st_next[0].ty   = shift_y;
        st_next[0].pa   = rot_xx * obj_x;
        st_next[0].pb   = rot_xy * obj_y;
        st_next[0].pc   = rot_yx * obj_x;
        st_next[0].pd   = rot_yy * obj_y;
        // normalized point
        st_next[1].xn = sat32(rnd(66'(st_reg[0].pa) + 66'(st_reg[0].pb), 30)
                              + 66'(st_reg[0].tx));
        st_next[1].yn = sat32(rnd(66'(st_reg[0].pc) + 66'(st_reg[0].pd), 30)
                              + 66'(st_reg[0].ty));
        // squares
        st_next[2].mxx = st_reg[1].xn * st_reg[1].xn;
        st_next[2].myy = st_reg[1].yn * st_reg[1].yn;
        st_next[2].mxy = st_reg[1].xn * st_reg[1].yn;
        // r2 and cross terms
        st_next[3].r2 = (r2u > 49'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(r2u[31:0]);
        st_next[3].xx = qmul(st_reg[2].mxx);
        st_next[3].yy = qmul(st_reg[2].myy);
        st_next[3].xy = qmul(st_reg[2].mxy);
        // first coefficient products
        st_next[4].m_r2r2 = st_reg[3].r2 * st_reg[3].r2;
        st_next[4].m_k1   = cfg.k1 * st_reg[3].r2;
        st_next[4].m_s1   = cfg.s1 * st_reg[3].r2;
        st_next[4].m_s3   = cfg.s3 * st_reg[3].r2;
        st_next[4].m_p1xy = cfg.p1 * st_reg[3].xy;
        st_next[4].m_p2xy = cfg.p2 * st_reg[3].xy;
        st_next[4].sx = sat32(66'(st_reg[3].r2) + 66'(st_reg[3].xx) + 66'(st_reg[3].xx));
        st_next[4].sy = sat32(66'(st_reg[3].r2) + 66'(st_reg[3].yy) + 66'(st_reg[3].yy));
        // r4 and rounding
        st_next[5].r4     = qmul(st_reg[4].m_r2r2);
        st_next[5].c_k1   = cmul(st_reg[4].m_k1);
        st_next[5].c_s1   = cmul(st_reg[4].m_s1);
        st_next[5].c_s3   = cmul(st_reg[4].m_s3);
        st_next[5].c_p1xy = cmul(st_reg[4].m_p1xy);
        st_next[5].c_p2xy = cmul(st_reg[4].m_p2xy);
        st_next[5].m_p2sx = cfg.p2 * st_reg[4].sx;
        st_next[5].m_p1sy = cfg.p1 * st_reg[4].sy;
        // r4 products
        st_next[6].m_r6   = st_reg[5].r4 * st_reg[5].r2;
        st_next[6].m_k2   = cfg.k2 * st_reg[5].r4;
        st_next[6].m_s2   = cfg.s2 * st_reg[5].r4;
        st_next[6].m_s4   = cfg.s4 * st_reg[5].r4;
        st_next[6].c_p2sx = cmul(st_reg[5].m_p2sx);
        st_next[6].c_p1sy = cmul(st_reg[5].m_p1sy);
        // r6
        st_next[7].r6   = qmul(st_reg[6].m_r6);
        st_next[7].c_k2 = cmul(st_reg[6].m_k2);
        st_next[7].c_s2 = cmul(st_reg[6].m_s2);
        st_next[7].c_s4 = cmul(st_reg[6].m_s4);
        st_next[8].m_k3 = cfg.k3 * st_reg[7].r6;
        // radial factor
        st_next[9].radial = sat32(66'sd65536 + 66'(st_reg[8].c_k1) + 66'(st_reg[8].c_k2)
                                  + 66'(cmul(st_reg[8].m_k3)));
        st_next[10].m_xr = st_reg[9].xn * st_reg[9].radial;
        st_next[10].m_yr = st_reg[9].yn * st_reg[9].radial;
        // distorted point
        st_next[11].xd = sat32(66'(qmul(st_reg[10].m_xr)) + 66'(st_reg[10].c_p1xy)
                               + 66'(st_reg[10].c_p1xy) + 66'(st_reg[10].c_p2sx)
                               + 66'(st_reg[10].c_s1) + 66'(st_reg[10].c_s2));
        st_next[11].yd = sat32(66'(qmul(st_reg[10].m_yr)) + 66'(st_reg[10].c_p1sy)
                               + 66'(st_reg[10].c_p2xy) + 66'(st_reg[10].c_p2xy)
                               + 66'(st_reg[10].c_s3) + 66'(st_reg[10].c_s4));
        // magnification
        st_next[12].m_u = signed'({1'b0, cfg.mag}) * st_reg[11].xd;
        st_next[12].m_v = signed'({1'b0, cfg.mag}) * st_reg[11].yd;
        // principal point
        st_next[13].u = sat32(rnd(66'(st_reg[12].m_u), 16) + 66'(cfg.u0));
        st_next[13].v = sat32(rnd(66'(st_reg[12].m_v), 16) + 66'(cfg.v0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[tpp_pkg::NStages-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < tpp_pkg::NStages; i++)
                st_reg[i] <= st_next[i];
        end
    end

    assign out_valid   = vld_reg[tpp_pkg::NStages-1];
    assign img_u       = st_reg[tpp_pkg::NStages-1].u;
    assign img_v       = st_reg[tpp_pkg::NStages-1].v;
    assign end_of_view = st_reg[tpp_pkg::NStages-1].last;

endmodule

>>> hdl/telecentric_point_projection.sv
// telecentric_point_projection: top level, apb registers plus projection pipeline
// one beat per cycle sustained while the output is not stalled
// the fourteen register stages advance together and stall only when the output
// register is full and not taken; ready follows from that output register
// reset clears all coefficient registers and the stage valid bits
// depends on tpp_pkg, tpp_cfg and tpp_pipe
module telecentric_point_projection (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tpp_pkg::AddrBits-1:0] paddr,
    input  logic [tpp_pkg::DataBits-1:0] pwdata,
    output logic [tpp_pkg::DataBits-1:0] prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [31:0]           obj_x,
    input  logic signed [31:0]           obj_y,
    input  logic signed [31:0]           rot_xx,
    input  logic signed [31:0]           rot_xy,
    input  logic signed [31:0]           rot_yx,
    input  logic signed [31:0]           rot_yy,
    input  logic signed [31:0]           shift_x,
    input  logic signed [31:0]           shift_y,
    input  logic                         last_point,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [31:0]           img_u,
    output logic signed [31:0]           img_v,
    output logic                         end_of_view
);

    tpp_pkg::cfg_t cfg;

    tpp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tpp_pipe u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .obj_x       (obj_x),
        .obj_y       (obj_y),
        .rot_xx      (rot_xx),
        .rot_xy      (rot_xy),
        .rot_yx      (rot_yx),
        .rot_yy      (rot_yy),
        .shift_x     (shift_x),
        .shift_y     (shift_y),
        .last_point  (last_point),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .img_u       (img_u),
        .img_v       (img_v),
        .end_of_view (end_of_view)
    );

endmodule

>>> hdl/tpp_checker.sv
// tpp_checker: port level assertions for telecentric_point_projection
// bound to the top level; depends on nothing else
module tpp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               pready,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] img_u,
    input logic signed [31:0] img_v
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(img_u) && $stable(img_v))
        else $error("output beat changed while stalled");

    a_ready_sink: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back pressure");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("apb wait state");

endmodule

bind telecentric_point_projection tpp_checker u_tpp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .img_u     (img_u),
    .img_v     (img_v)
);

>>> tb/sv/tpp_checker.sv
// tpp_monitor: watches the point and image channels plus register writes of the
// projection block, predicts each image point and compares field by field
// depends on tpp_pkg
module tpp_monitor (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [tpp_pkg::AddrBits-1:0] paddr,
    input  logic [tpp_pkg::DataBits-1:0] pwdata,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic signed [31:0]           obj_x,
    input  logic signed [31:0]           obj_y,
    input  logic signed [31:0]           rot_xx,
    input  logic signed [31:0]           rot_xy,
    input  logic signed [31:0]           rot_yx,
    input  logic signed [31:0]           rot_yy,
    input  logic signed [31:0]           shift_x,
    input  logic signed [31:0]           shift_y,
    input  logic                         last_point,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic signed [31:0]           img_u,
    input  logic signed [31:0]           img_v,
    input  logic                         end_of_view,
    output int                           errors,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic               eov;
    } image_pt_t;

    localparam longint S32Max = 64'sd2147483647;
    localparam longint S32Min = -64'sd2147483648;
    localparam longint OneQ16 = 64'sd65536;

    tpp_pkg::cfg_t cfg;
    image_pt_t     image_q[$];

    function automatic longint clamp32(longint v);
        if (v > S32Max)
            return S32Max;
        if (v < S32Min)
            return S32Min;
        return v;
    endfunction

    // round half up, arithmetic shift is floor
    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint mul_q16(longint a, longint b);
        return clamp32(rnd_shift(a * b, 16));
    endfunction

    function automatic longint mul_coef(longint c, longint t);
        return rnd_shift(c * t, 40);
    endfunction

    function automatic longint rotate_pt(longint ra, longint a, longint rb, longint b,
                                         longint sh);
        logic signed [65:0] acc;
        acc = 66'(ra * a) + 66'(rb * b) + (66'sd1 <<< 29);
        acc = acc >>> 30;
        return clamp32(longint'(acc) + sh);
    endfunction

    function automatic image_pt_t project(longint x, longint y, longint rxx, longint rxy,
                                          longint ryx, longint ryy, longint tx, longint ty,
                                          logic eov);
        image_pt_t r;
        longint xn, yn, r2, r4, r6, rad, xx, yy, xy, xd, yd;
        logic [64:0] sq;
        xn = rotate_pt(rxx, x, rxy, y, tx);
        yn = rotate_pt(ryx, x, ryy, y, ty);
        sq = 65'(xn * xn) + 65'(yn * yn) + 65'd32768;
        sq = sq >> 16;
        r2 = (sq > 65'(S32Max)) ? S32Max : longint'(sq);
        r4 = mul_q16(r2, r2);
        r6 = mul_q16(r4, r2);
        rad = clamp32(OneQ16 + mul_coef(cfg.k1, r2) + mul_coef(cfg.k2, r4)
                      + mul_coef(cfg.k3, r6));
        xx = mul_q16(xn, xn);
        yy = mul_q16(yn, yn);
        xy = mul_q16(xn, yn);
        xd = clamp32(mul_q16(xn, rad) + 2 * mul_coef(cfg.p1, xy)
                     + mul_coef(cfg.p2, clamp32(r2 + 2 * xx))
                     + mul_coef(cfg.s1, r2) + mul_coef(cfg.s2, r4));
        yd = clamp32(mul_q16(yn, rad) + mul_coef(cfg.p1, clamp32(r2 + 2 * yy))
                     + 2 * mul_coef(cfg.p2, xy)
                     + mul_coef(cfg.s3, r2) + mul_coef(cfg.s4, r4));
        r.u = 32'(clamp32(rnd_shift(longint'({32'd0, cfg.mag}) * xd, 16) + cfg.u0));
        r.v = 32'(clamp32(rnd_shift(longint'({32'd0, cfg.mag}) * yd, 16) + cfg.v0));
        r.eov = eov;
        return r;
    endfunction

    assign pending = image_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        image_pt_t want;
        logic [2:0] idx;
        if (!rst_n)
        begin
            cfg = '0;
            errors <= 0;
            image_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                idx = paddr[5:3];
                case (tpp_pkg::reg_idx_t'(idx))
                    tpp_pkg::REG_MAG:    cfg.mag = pwdata[31:0];
                    tpp_pkg::REG_PP:
                    begin
                        cfg.u0 = pwdata[63:32];
                        cfg.v0 = pwdata[31:0];
                    end
                    tpp_pkg::REG_K1:     cfg.k1 = pwdata[31:0];
                    tpp_pkg::REG_K2:     cfg.k2 = pwdata[31:0];
                    tpp_pkg::REG_K3:     cfg.k3 = pwdata[31:0];
                    tpp_pkg::REG_TANG:
                    begin
                        cfg.p1 = pwdata[63:32];
                        cfg.p2 = pwdata[31:0];
                    end
                    tpp_pkg::REG_PRISMX:
                    begin
                        cfg.s1 = pwdata[63:32];
                        cfg.s2 = pwdata[31:0];
                    end
                    tpp_pkg::REG_PRISMY:
                    begin
                        cfg.s3 = pwdata[63:32];
                        cfg.s4 = pwdata[31:0];
                    end
                    default:    ;
                endcase
            end
            if (in_valid && in_ready)
                image_q.push_back(project(obj_x, obj_y, rot_xx, rot_xy, rot_yx, rot_yy,
                                          shift_x, shift_y, last_point));
            if (out_valid && out_ready)
            begin
                if (image_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected beat u=%0d v=%0d eov=%0b",
                                 img_u, img_v, end_of_view);
                    errors <= errors + 1;
                end
                else
                begin
                    want = image_q.pop_front();
                    if (want.u !== img_u || want.v !== img_v || want.eov !== end_of_view)
                    begin
                        if (errors < 10)
                            $display("mismatch: exp u=%0d v=%0d eov=%0b got u=%0d v=%0d eov=%0b",
                                     want.u, want.v, want.eov, img_u, img_v, end_of_view);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

>>> tb/sv/testbench.sv
// testbench: stimulus and verdict for telecentric_point_projection
// drives register writes and point beats with random gaps; depends on tpp_pkg,
// tpp_monitor and the block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic                         clk;
    logic                         rst_n;
    logic                         psel, penable, pwrite, pready;
    logic [tpp_pkg::AddrBits-1:0] paddr;
    logic [tpp_pkg::DataBits-1:0] pwdata, prdata;
    logic                         in_valid, in_ready, out_valid, out_ready;
    logic signed [31:0]  obj_x, obj_y, rot_xx, rot_xy, rot_yx, rot_yy, shift_x, shift_y;
    logic                         last_point;
    logic signed [31:0]           img_u, img_v;
    logic                         end_of_view;
    int                           errors, pending;
    bit                           stall_en;

    telecentric_point_projection dut (.*);

    tpp_monitor chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [31:0] rand_word(int mode);
        case (mode)
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return $urandom_range(0, 32'h0003ffff) - 32'h00020000;
        endcase
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(5, 30);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 2);
    endfunction

    task automatic reg_write(tpp_pkg::reg_idx_t idx, logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tpp_pkg::AddrBits'(idx) << 3;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] rxx,
                              logic [31:0] rxy, logic [31:0] ryx, logic [31:0] ryy,
                              logic [31:0] tx, logic [31:0] ty, logic lp);
        in_valid   <= 1'b1;
        obj_x      <= x;
        obj_y      <= y;
        rot_xx     <= rxx;
        rot_xy     <= rxy;
        rot_yx     <= ryx;
        rot_yy     <= ryy;
        shift_x    <= tx;
        shift_y    <= ty;
        last_point <= lp;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_random(int cnt, bit gaps);
        int g;
        int m;
        logic [31:0] c, s;
        for (int i = 0; i < cnt; i++)
        begin
            m = $urandom_range(0, 9);
            if (m < 7)
            begin
                // scaled rotation pose from random c and s, with a modest point
                c = $urandom_range(0, 32'h80000000) - 32'h40000000;
                s = $urandom_range(0, 32'h80000000) - 32'h40000000;
                send_point(rand_word(3), rand_word(3), c, -s, s, c,
                           rand_word(3), rand_word(3), $urandom_range(0, 1));
            end
            else
                send_point(rand_word($urandom_range(0, 3)), rand_word($urandom_range(0, 3)),
                           rand_word($urandom_range(0, 3)), rand_word($urandom_range(0, 3)),
                           rand_word($urandom_range(0, 3)), rand_word($urandom_range(0, 3)),
                           rand_word($urandom_range(0, 3)), rand_word($urandom_range(0, 3)),
                           $urandom_range(0, 1));
            g = gaps ? gap_len() : 0;
            if (g > 0)
            begin
                in_valid <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic load_coefs(logic [31:0] mag, logic [63:0] pp, logic [31:0] k1,
                              logic [31:0] k2, logic [31:0] k3, logic [63:0] tang,
                              logic [63:0] px, logic [63:0] py);
        reg_write(tpp_pkg::REG_MAG, {32'd0, mag});
        reg_write(tpp_pkg::REG_PP, pp);
        reg_write(tpp_pkg::REG_K1, {32'd0, k1});
        reg_write(tpp_pkg::REG_K2, {32'd0, k2});
        reg_write(tpp_pkg::REG_K3, {32'd0, k3});
        reg_write(tpp_pkg::REG_TANG, tang);
        reg_write(tpp_pkg::REG_PRISMX, px);
        reg_write(tpp_pkg::REG_PRISMY, py);
    endtask

    always @(posedge clk)
    begin
        if (stall_en)
            out_ready <= ($urandom_range(0, 15) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_valid = 0; obj_x = 0; obj_y = 0; rot_xx = 0; rot_xy = 0; rot_yx = 0;
        rot_yy = 0; shift_x = 0; shift_y = 0; last_point = 0; stall_en = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity and extreme poses, unit magnification, no distortion
        load_coefs(32'h00010000, {32'h00100000, 32'hfff00000}, 0, 0, 0, 0, 0, 0);
        send_point(32'h00010000, 32'h00020000, 32'h40000000, 0, 0, 32'h40000000, 0, 0, 0);
        send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1);
        send_point(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0);
        send_point(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                   32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1);
        send_point(32'hffffffff, 32'h00000001, 32'h40000000, 32'hc0000000,
                   32'h40000000, 32'h40000000, 32'h00008000, 32'hffff8000, 0);
        send_point(0, 0, 0, 0, 0, 0, 0, 0, 1);
        in_valid <= 1'b0;
        drain();

        // directed: extreme coefficients
        load_coefs(32'hffffffff, {32'h7fffffff, 32'h80000000}, 32'h7fffffff, 32'h80000000,
                   32'h7fffffff, {32'h7fffffff, 32'h80000000},
                   {32'h80000000, 32'h7fffffff}, {32'h7fffffff, 32'h80000000});
        for (int i = 0; i < 6; i++)
            send_point(rand_word(i % 4), rand_word((i + 1) % 4), 32'h40000000, 0, 0,
                       32'h40000000, rand_word(3), rand_word(3), i[0]);
        send_point(32'h00020000, 32'h00030000, 32'h2d413ccd, 32'hd2bec333,
                   32'h2d413ccd, 32'h2d413ccd, 32'h00010000, 32'hffff0000, 1);
        in_valid <= 1'b0;
        drain();

        // random phases over several coefficient settings
        stall_en <= 1'b1;
        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph == 6)
                load_coefs(0, 0, 0, 0, 0, 0, 0, 0);
            else
                load_coefs($urandom_range(0, 32'h00040000), {$urandom, $urandom},
                           $urandom, $urandom, $urandom, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom});
            send_random(100, 1);
            // back-to-back run
            send_random(60, 0);
            drain();
        end
        stall_en <= 1'b0;
        send_random(270, 0);
        drain();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> filelist.f
hdl/tpp_pkg.sv
hdl/tpp_cfg.sv
hdl/tpp_pipe.sv
hdl/telecentric_point_projection.sv
hdl/tpp_checker.sv
tb/sv/tpp_checker.sv
tb/sv/testbench.sv
